// ----- hw/rtl/dld_pkg.sv -----
// Shared types, codes and symbol tables for the DEFLATE length/distance decoder.
package dld_pkg;

    localparam logic [1:0] CMD_LEN   = 2'd0;
    localparam logic [1:0] CMD_DIST  = 2'd1;
    localparam logic [1:0] CMD_FIXED = 2'd2;
    localparam logic [1:0] CMD_BIT   = 2'd3;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_BAD_LEN  = 2'd1;
    localparam logic [1:0] ERR_BAD_DIST = 2'd2;
    localparam logic [1:0] ERR_UNEXP    = 2'd3;

    localparam int LMIN = 3;
    localparam int DMIN = 1;
    localparam logic [3:0] FIXED_CODE_BITS = 4'd5;
    localparam logic [8:0] LEN_SYM_FIRST = 9'd257;
    localparam logic [8:0] LEN_SYM_LAST  = 9'd285;
    localparam logic [8:0] LEN_MAX       = 9'd258;
    localparam logic [8:0] DIST_SYM_LAST = 9'd29;

    typedef struct packed {
        logic [15:0] value;
        logic        is_dist;
        logic [1:0]  err;
    } result_t;

    // Extra-bit count for a length symbol offset (symbol - 257), 0..27.
    function automatic logic [3:0] len_nbits(input logic [4:0] s);
        logic [2:0] df;
        df = s[4:2];
        if (s < 5'd8)
            len_nbits = 4'd0;
        else
            len_nbits = {1'b0, df} - 4'd1;
    endfunction

    function automatic logic [14:0] len_base(input logic [4:0] s);
        logic [2:0]  df;
        logic [3:0]  nb;
        df = s[4:2];
        nb = len_nbits(s);
        if (s < 5'd8)
            len_base = 15'({10'd0, s} + 15'(LMIN));
        else
            len_base = (15'd2 << df) + (15'({13'd0, s[1:0]}) << nb) + 15'(LMIN);
    endfunction

    // Extra-bit count for a distance symbol 0..29.
    function automatic logic [3:0] dist_nbits(input logic [4:0] sym);
        logic [3:0] df;
        df = sym[4:1];
        if (sym < 5'd4)
            dist_nbits = 4'd0;
        else
            dist_nbits = df - 4'd1;
    endfunction

    function automatic logic [14:0] dist_base(input logic [4:0] sym);
        logic [3:0] df;
        logic [3:0] nb;
        df = sym[4:1];
        nb = dist_nbits(sym);
        if (sym < 5'd4)
            dist_base = {10'd0, sym} + 15'(DMIN);
        else
            dist_base = (15'd1 << df) + (15'({14'd0, sym[0]}) << nb) + 15'(DMIN);
    endfunction

endpackage

// ----- hw/rtl/deflate_length_distance_decode_top.sv -----
// Top level of the DEFLATE length/distance extra-bits decoder.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, cmd, symbol, stream_bit | sink
//  output  | out_valid, out_stall, decoded_value,       | source
//          | is_distance, error_code                   |
//
// One item per cycle while in_stall is low; a result, when an item causes one, is
// registered into the output register, or into the skid entry under output stall.
// The decode state advances in a single step from the item and the held state.
// A one-entry skid stage behind the output register keeps input open while a single
// result waits under output stall; in_stall rises only while the skid entry is full.
// rst_n clears the decode state and both valid flags asynchronously.
module deflate_length_distance_decode_top
    import dld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [8:0]  symbol,
    input  logic        stream_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] decoded_value,
    output logic        is_distance,
    output logic [1:0]  error_code
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CODE  = 2'd1;
    localparam logic [1:0] PH_EXTRA = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  bits_left_reg, bits_left_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [12:0] extra_reg, extra_next;
    logic [14:0] base_reg, base_next;
    logic [4:0]  code_reg, code_next;
    logic        dist_reg, dist_next;

    logic        out_valid_reg, skid_valid_reg;
    result_t     out_reg, skid_reg;

    logic        accept;
    logic        res_valid;
    result_t     res;
    logic        out_take;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign out_valid     = out_valid_reg;
    assign decoded_value = out_reg.value;
    assign is_distance   = out_reg.is_dist;
    assign error_code    = out_reg.err;

    always_comb
    begin
        logic        dist_go;
        logic [8:0]  dsym;
        logic [4:0]  lsym;
        logic [3:0]  nb;
        logic [14:0] bv;
        logic [12:0] ex;
        logic [3:0]  bl;

        phase_next     = phase_reg;
        bits_left_next = bits_left_reg;
        bit_index_next = bit_index_reg;
        extra_next     = extra_reg;
        base_next      = base_reg;
        code_next      = code_reg;
        dist_next      = dist_reg;
        res_valid      = 1'b0;
        res            = '0;
        dist_go        = 1'b0;
        dsym           = symbol;
        lsym           = 5'(symbol - LEN_SYM_FIRST);
        nb             = 4'd0;
        bv             = 15'd0;
        ex             = 13'd0;
        bl             = 4'd0;

        if (accept)
        begin
            if (cmd != CMD_BIT)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_valid = 1'b1;
                    res.err   = ERR_UNEXP;
                end
                else
                begin
                    case (cmd)
                        CMD_LEN:
                        begin
                            if (symbol < LEN_SYM_FIRST || symbol > LEN_SYM_LAST)
                            begin
                                res_valid = 1'b1;
                                res.err   = ERR_BAD_LEN;
                            end
                            else
                            begin
                                if (symbol == LEN_SYM_LAST)
                                begin
                                    bv = {6'd0, LEN_MAX};
                                    nb = 4'd0;
                                end
                                else
                                begin
                                    bv = len_base(lsym);
                                    nb = len_nbits(lsym);
                                end
                                if (nb == 4'd0)
                                begin
                                    res_valid = 1'b1;
                                    res.value = {1'b0, bv};
                                end
                                else
                                begin
                                    base_next      = bv;
                                    bits_left_next = nb;
                                    bit_index_next = 4'd0;
                                    extra_next     = 13'd0;
                                    dist_next      = 1'b0;
                                    phase_next     = PH_EXTRA;
                                end
                            end
                        end
                        CMD_DIST:
                        begin
                            dist_go = 1'b1;
                        end
                        default:
                        begin
                            code_next      = 5'd0;
                            bit_index_next = 4'd0;
                            dist_next      = 1'b1;
                            phase_next     = PH_CODE;
                        end
                    endcase
                end
            end
            else
            begin
                case (phase_reg)
                    PH_CODE:
                    begin
                        code_next      = {code_reg[3:0], stream_bit};
                        bit_index_next = bit_index_reg + 4'd1;
                        if (bit_index_next >= FIXED_CODE_BITS)
                        begin
                            bit_index_next = 4'd0;
                            dsym           = {4'd0, code_next};
                            dist_go        = 1'b1;
                        end
                    end
                    PH_EXTRA:
                    begin
                        ex             = extra_reg | (13'(stream_bit) << bit_index_reg);
                        extra_next     = ex;
                        bit_index_next = bit_index_reg + 4'd1;
                        bl             = bits_left_reg - 4'd1;
                        bits_left_next = bl;
                        if (bl == 4'd0)
                        begin
                            phase_next     = PH_IDLE;
                            bit_index_next = 4'd0;
                            res_valid      = 1'b1;
                            res.value      = {1'b0, base_reg} + {3'd0, ex};
                            res.is_dist    = dist_reg;
                        end
                    end
                    default:
                    begin
                        // stream bit with no decode open
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.err    = ERR_UNEXP;
                    end
                endcase
            end

            if (dist_go)
            begin
                if (dsym > DIST_SYM_LAST)
                begin
                    phase_next  = PH_IDLE;
                    res_valid   = 1'b1;
                    res.is_dist = 1'b1;
                    res.err     = ERR_BAD_DIST;
                end
                else
                begin
                    bv = dist_base(dsym[4:0]);
                    nb = dist_nbits(dsym[4:0]);
                    if (nb == 4'd0)
                    begin
                        phase_next  = PH_IDLE;
                        res_valid   = 1'b1;
                        res.value   = {1'b0, bv};
                        res.is_dist = 1'b1;
                    end
                    else
                    begin
                        base_next      = bv;
                        bits_left_next = nb;
                        bit_index_next = 4'd0;
                        extra_next     = 13'd0;
                        dist_next      = 1'b1;
                        phase_next     = PH_EXTRA;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bits_left_reg <= 4'd0;
            bit_index_reg <= 4'd0;
            extra_reg     <= 13'd0;
            base_reg      <= 15'd0;
            code_reg      <= 5'd0;
            dist_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            bit_index_reg <= bit_index_next;
            extra_reg     <= extra_next;
            base_reg      <= base_next;
            code_reg      <= code_next;
            dist_reg      <= dist_next;
        end
    end

    // Output register with a one-entry skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (res_valid)
                out_reg <= res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with output register empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost during output stall");

    a_extra_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EXTRA |-> bits_left_reg != 4'd0 && bit_index_reg < 4'd13)
        else $error("extra-bit counters out of range");

    a_code_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CODE |-> bit_index_reg < FIXED_CODE_BITS && dist_reg)
        else $error("fixed code index out of range");

    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.err != ERR_OK |-> out_reg.value == 16'd0)
        else $error("error result carries a value");
`endif

endmodule

// ----- verif/deflate_length_distance_decode_top_tb.sv -----
// Self-checking testbench for the DEFLATE length/distance decoder, with its scoreboard class.
`timescale 1ns / 100ps

import dld_pkg::*;

typedef enum logic [1:0] {
    DEC_IDLE  = 2'd0,
    DEC_FIXED = 2'd1,
    DEC_EXTRA = 2'd2
} decode_phase_t;

class length_distance_tracker;
    decode_phase_t phase;
    logic [3:0]    bits_left;
    logic [3:0]    bit_pos;
    logic [12:0]   extra;
    logic [14:0]   base_value;
    logic [4:0]    code_bits;
    logic          want_distance;
    result_t       pending_codes[$];
    int            errors;

    function new();
        phase         = DEC_IDLE;
        bits_left     = '0;
        bit_pos       = '0;
        extra         = '0;
        base_value    = '0;
        code_bits     = '0;
        want_distance = 1'b0;
        errors        = 0;
    endfunction

    function void push(logic [15:0] v, logic d, logic [1:0] e);
        result_t r;
        r.value   = v;
        r.is_dist = d;
        r.err     = e;
        pending_codes.push_back(r);
    endfunction

    // Load base and count, then gather extra bits LSB first.
    function void arm(logic [15:0] base, logic [3:0] nb, logic d);
        base_value    = base[14:0];
        bits_left     = nb;
        bit_pos       = '0;
        extra         = '0;
        want_distance = d;
        phase         = DEC_EXTRA;
    endfunction

    function void open_distance(logic [8:0] sym);
        logic [4:0]  s5;
        logic [3:0]  grp;
        logic [3:0]  nb;
        logic [15:0] base;
        if (sym > DIST_SYM_LAST) begin
            phase = DEC_IDLE;
            push(16'd0, 1'b1, ERR_BAD_DIST);
            return;
        end
        s5 = sym[4:0];
        if (s5 < 5'd4) begin
            nb   = 4'd0;
            base = 16'(s5) + 16'(DMIN);
        end
        else begin
            grp  = s5[4:1];
            nb   = grp - 4'd1;
            base = (16'd1 << grp) + (16'(s5[0]) << nb) + 16'(DMIN);
        end
        if (nb == 4'd0) begin
            phase = DEC_IDLE;
            push(base, 1'b1, ERR_OK);
        end
        else
            arm(base, nb, 1'b1);
    endfunction

    function void take_item(logic [1:0] c, logic [8:0] s, logic b);
        logic [4:0]  off;
        logic [2:0]  grp;
        logic [3:0]  nb;
        logic [15:0] base;
        if (c != CMD_BIT) begin
            if (phase != DEC_IDLE)
                push(16'd0, 1'b0, ERR_UNEXP);
            else if (c == CMD_LEN) begin
                if (s < LEN_SYM_FIRST || s > LEN_SYM_LAST)
                    push(16'd0, 1'b0, ERR_BAD_LEN);
                else if (s == LEN_SYM_LAST)
                    push(16'(LEN_MAX), 1'b0, ERR_OK);
                else begin
                    off = 5'(s - LEN_SYM_FIRST);
                    if (off < 5'd8)
                        push(16'(off) + 16'(LMIN), 1'b0, ERR_OK);
                    else begin
                        grp  = off[4:2];
                        nb   = {1'b0, grp} - 4'd1;
                        base = (16'd2 << grp) + (16'(off[1:0]) << nb) + 16'(LMIN);
                        arm(base, nb, 1'b0);
                    end
                end
            end
            else if (c == CMD_DIST)
                open_distance(s);
            else begin
                code_bits     = '0;
                bit_pos       = '0;
                want_distance = 1'b1;
                phase         = DEC_FIXED;
            end
        end
        else begin
            case (phase)
                DEC_FIXED: begin
                    code_bits = {code_bits[3:0], b};
                    bit_pos   = bit_pos + 4'd1;
                    if (bit_pos >= FIXED_CODE_BITS) begin
                        bit_pos = '0;
                        open_distance({4'd0, code_bits});
                    end
                end
                DEC_EXTRA: begin
                    extra     = extra | (13'(b) << bit_pos);
                    bit_pos   = bit_pos + 4'd1;
                    bits_left = bits_left - 4'd1;
                    if (bits_left == 4'd0) begin
                        phase   = DEC_IDLE;
                        bit_pos = '0;
                        push(16'(base_value) + 16'(extra), want_distance, ERR_OK);
                    end
                end
                default: begin
                    phase = DEC_IDLE;
                    push(16'd0, 1'b0, ERR_UNEXP);
                end
            endcase
        end
    endfunction

    function void check_result(logic [15:0] v, logic d, logic [1:0] e);
        result_t want;
        if (pending_codes.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: unexpected result value=%0d dist=%0b err=%0d", v, d, e);
            return;
        end
        want = pending_codes.pop_front();
        if (want.value !== v || want.is_dist !== d || want.err !== e) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: expected value=%0d dist=%0b err=%0d, ",
                          "got value=%0d dist=%0b err=%0d"},
                         want.value, want.is_dist, want.err, v, d, e);
        end
    endfunction

    function int pending();
        return pending_codes.size();
    endfunction
endclass

module deflate_length_distance_decode_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 600;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd        = CMD_LEN;
    logic [8:0]  symbol     = '0;
    logic        stream_bit = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [15:0] decoded_value;
    logic        is_distance;
    logic [1:0]  error_code;

    int          cycles     = 0;
    int          stall_left = 0;
    bit          no_idle    = 1'b0;

    length_distance_tracker tracker = new();

    deflate_length_distance_decode_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .symbol        (symbol),
        .stream_bit    (stream_bit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .decoded_value (decoded_value),
        .is_distance   (is_distance),
        .error_code    (error_code)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check each output transfer, then draw the stall before the next one.
    always @(posedge clk)
    begin : result_side
        int unsigned n;
        if (out_valid && !out_stall)
        begin
            tracker.check_result(decoded_value, is_distance, error_code);
            n = no_idle ? 0 : $urandom_range(0, 15);
            stall_left <= n;
            out_stall  <= (n != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Hold the item until it transfers, then hand it to the tracker.
    task automatic send_item(input logic [1:0] c, input logic [8:0] s, input logic b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        symbol     <= s;
        stream_bit <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_item(c, s, b);
    endtask

    initial
    begin
        int unsigned roll;
        int unsigned bit_mode;
        logic        b;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray bit, length extremes, bad symbols, busy commands
        send_item(CMD_BIT, 9'd0, 1'b1);
        send_item(CMD_LEN, 9'd257, 1'b0);
        send_item(CMD_LEN, 9'd285, 1'b0);
        send_item(CMD_LEN, 9'd256, 1'b0);
        send_item(CMD_LEN, 9'd286, 1'b0);
        send_item(CMD_LEN, 9'd511, 1'b1);
        send_item(CMD_LEN, 9'd265, 1'b0);
        send_item(CMD_FIXED, 9'd0, 1'b0);
        send_item(CMD_BIT, 9'd511, 1'b1);
        send_item(CMD_DIST, 9'd0, 1'b0);
        send_item(CMD_DIST, 9'd3, 1'b0);
        send_item(CMD_DIST, 9'd30, 1'b0);
        send_item(CMD_DIST, 9'd511, 1'b0);
        send_item(CMD_FIXED, 9'd0, 1'b0);
        repeat (5) send_item(CMD_BIT, 9'd0, 1'b1);
        send_item(CMD_FIXED, 9'd0, 1'b0);
        send_item(CMD_BIT, 9'd0, 1'b0);
        send_item(CMD_BIT, 9'd0, 1'b0);
        send_item(CMD_BIT, 9'd0, 1'b1);
        send_item(CMD_LEN, 9'd257, 1'b0);
        send_item(CMD_BIT, 9'd0, 1'b0);
        send_item(CMD_BIT, 9'd0, 1'b0);
        send_item(CMD_BIT, 9'd0, 1'b1);

        // random: mostly well-formed symbol plus bit sequences, some noise
        bit_mode = 2;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = ((i / 100) % 3 == 2);
            roll = $urandom_range(0, 99);
            if (tracker.phase == DEC_IDLE)
            begin
                bit_mode = $urandom_range(0, 3);
                if (roll < 4)
                    send_item(CMD_BIT, 9'($urandom), 1'($urandom));
                else if (roll < 8)
                    send_item(CMD_LEN, 9'($urandom), 1'($urandom));
                else if (roll < 12)
                    send_item(CMD_DIST, 9'($urandom), 1'($urandom));
                else if (roll < 55)
                    send_item(CMD_LEN, 9'($urandom_range(257, 285)), 1'($urandom));
                else if (roll < 75)
                    send_item(CMD_DIST, 9'($urandom_range(0, 29)), 1'($urandom));
                else
                    send_item(CMD_FIXED, 9'($urandom), 1'($urandom));
            end
            else
            begin
                if (roll < 5)
                    send_item(2'($urandom_range(0, 2)), 9'($urandom), 1'($urandom));
                else
                begin
                    if (bit_mode == 0)
                        b = 1'b0;
                    else if (bit_mode == 1)
                        b = 1'b1;
                    else
                        b = 1'($urandom);
                    send_item(CMD_BIT, 9'($urandom), b);
                end
            end
        end
        in_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
